/* design/rrmq_pkg.sv */
`default_nettype none
package rrmq_pkg;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int BEGIN_W   = 24;
    localparam int IMG_W     = 25;
    localparam int SPACE_W   = 16;
    localparam int PIECE_W   = 13;
    localparam int STATUS_W  = 2;
    localparam int AKIND_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W   = 2 * IMG_W;

    // Stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    // Configuration reset values
    localparam logic [IMG_W-1:0]   IMAGE_SIZE_RST = IMG_W'(65536);
    localparam logic [PIECE_W-1:0] MAX_PIECE_RST  = PIECE_W'(128);
    localparam logic [PIECE_W-1:0] HASH_BYTES_RST = PIECE_W'(64);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_SIZE = 2'd0,
        CFG_MAX_PIECE  = 2'd1,
        CFG_HASH_BYTES = 2'd2
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_RANGE  = 2'd0,
        KIND_HASH   = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_ANSWER = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_NODATA  = 2'd3
    } t_status;

    typedef enum logic [AKIND_W-1:0] {
        AKIND_NONE  = 2'd0,
        AKIND_HASH  = 2'd1,
        AKIND_CHUNK = 2'd2
    } t_akind;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HASH = 2'd1,
        MODE_XFER = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_DECODE    = 3'd1,
        S_WALK      = 3'd2,
        S_APPEND    = 3'd3,
        S_ANS_CALC  = 3'd4,
        S_ANS_APPLY = 3'd5,
        S_DONE      = 3'd6
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic walk_step;
        logic append;
        logic piece_calc;
        logic piece_apply;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_walk;
        logic need_piece;
        logic hit;
        logic walk_end;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* design/rrmq_ram.sv */
`default_nettype none
module rrmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* design/rrmq_ctrl.sv */
`default_nettype none
module rrmq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rrmq_pkg::t_stat i_stat,
    output rrmq_pkg::t_cmd     o_cmd
);
    rrmq_pkg::t_state r_state;
    rrmq_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrmq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rrmq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = rrmq_pkg::S_DECODE;
                end
            end
            rrmq_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_stat.need_walk) begin
                    n_state = rrmq_pkg::S_WALK;
                end else if (i_stat.need_piece) begin
                    n_state = rrmq_pkg::S_ANS_CALC;
                end else begin
                    n_state = rrmq_pkg::S_DONE;
                end
            end
            rrmq_pkg::S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.hit) begin
                    n_state = rrmq_pkg::S_DONE;
                end else if (i_stat.walk_end) begin
                    n_state = rrmq_pkg::S_APPEND;
                end
            end
            rrmq_pkg::S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = rrmq_pkg::S_DONE;
            end
            rrmq_pkg::S_ANS_CALC: begin
                o_cmd.piece_calc = 1'b1;
                n_state          = rrmq_pkg::S_ANS_APPLY;
            end
            rrmq_pkg::S_ANS_APPLY: begin
                o_cmd.piece_apply = 1'b1;
                n_state           = rrmq_pkg::S_DONE;
            end
            rrmq_pkg::S_DONE: begin
                // Hand the result over and take the next request at once
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    o_in_ready   = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = rrmq_pkg::S_DECODE;
                    end else begin
                        n_state = rrmq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = rrmq_pkg::S_IDLE;
            end
        endcase
    end

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("result loaded while output register still full");

    a_capture_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == rrmq_pkg::S_DECODE))
        else $error("accepted request not decoded next cycle");
endmodule
`default_nettype wire

/* design/rrmq_dp.sv */
`default_nettype none
module rrmq_dp #(
    parameter int RING_DEPTH = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rrmq_pkg::t_cmd                     i_cmd,
    output rrmq_pkg::t_stat                         o_stat,
    input  wire logic                               i_cfg_we,
    input  wire logic [rrmq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rrmq_pkg::IMG_W-1:0]         i_cfg_wdata,
    input  wire logic [rrmq_pkg::KIND_W-1:0]        i_kind,
    input  wire logic [rrmq_pkg::BEGIN_W-1:0]       i_range_begin,
    input  wire logic [rrmq_pkg::IMG_W-1:0]         i_range_end,
    input  wire logic [rrmq_pkg::SPACE_W-1:0]       i_space_left,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic [rrmq_pkg::STATUS_W-1:0]           o_status,
    output logic [rrmq_pkg::AKIND_W-1:0]            o_answer_kind,
    output logic [rrmq_pkg::BEGIN_W-1:0]            o_piece_offset,
    output logic [rrmq_pkg::PIECE_W-1:0]            o_piece_length,
    output logic                                    o_has_answers
);
    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int AW = rrmq_pkg::IMG_W;
    localparam int PW = rrmq_pkg::PIECE_W;

    // Configuration
    logic [AW-1:0] r_image_size;
    logic [PW-1:0] r_max_piece;
    logic [PW-1:0] r_hash_bytes;

    // Captured request
    rrmq_pkg::t_kind               r_kind;
    logic [rrmq_pkg::BEGIN_W-1:0]  r_b;
    logic [AW-1:0]                 r_e;
    logic [rrmq_pkg::SPACE_W-1:0]  r_space;

    // Ring control
    logic [IW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    rrmq_pkg::t_mode  r_mode;

    // Walk
    logic [IW-1:0] r_cur;
    logic [CW-1:0] r_issued;
    logic          r_cmp_valid;
    logic [IW-1:0] r_cmp_idx;

    // Piece
    logic [AW-1:0] r_p_s;
    logic [AW-1:0] r_p_en;
    logic [PW-1:0] r_p_size;

    // Staged result and output register
    rrmq_pkg::t_status             r_res_status;
    rrmq_pkg::t_akind              r_res_akind;
    logic [rrmq_pkg::BEGIN_W-1:0]  r_res_off;
    logic [PW-1:0]                 r_res_len;
    logic                          r_out_valid;
    logic [rrmq_pkg::STATUS_W-1:0] r_out_status;
    logic [rrmq_pkg::AKIND_W-1:0]  r_out_akind;
    logic [rrmq_pkg::BEGIN_W-1:0]  r_out_off;
    logic [PW-1:0]                 r_out_len;
    logic                          r_out_has;

    // Ring memory: {end, start}
    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    logic [rrmq_pkg::ENTRY_W-1:0] ram_wdata;
    logic [IW-1:0]                ram_raddr;
    logic [rrmq_pkg::ENTRY_W-1:0] ram_rdata;

    logic [AW-1:0] b_ext;
    logic [AW-1:0] os;
    logic [AW-1:0] oe;
    logic          full;
    logic          bad;
    logic          empty;
    logic          lo_hit;
    logic          hi_hit;
    logic          hit;
    logic [AW-1:0] new_start;
    logic [AW-1:0] new_end;
    logic [IW-1:0] cur_inc;
    logic [IW-1:0] head_inc;
    logic [IW:0]   tail_sum;
    logic [IW-1:0] tail;
    logic [AW-1:0] diff;
    logic [PW-1:0] size_a;
    logic [PW-1:0] size_b;
    logic [AW-1:0] p_next;
    logic          drained;

    rrmq_pkg::t_status dec_status;
    rrmq_pkg::t_akind  dec_akind;

    rrmq_ram #(
        .WIDTH (rrmq_pkg::ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Range checks and merge compare
    always_comb begin
        b_ext     = {1'b0, r_b};
        os        = ram_rdata[AW-1:0];
        oe        = ram_rdata[2*AW-1:AW];
        full      = (r_count == CW'(RING_DEPTH));
        bad       = (b_ext >= r_image_size) || (r_e > r_image_size) || (b_ext > r_e);
        empty     = (b_ext == r_e);
        lo_hit    = (b_ext <= os) && (r_e >= os);
        hi_hit    = (b_ext > os) && (b_ext <= oe);
        hit       = r_cmp_valid && (lo_hit || hi_hit);
        new_start = lo_hit ? b_ext : os;
        new_end   = (r_e > oe) ? r_e : oe;
    end

    // Ring index arithmetic
    always_comb begin
        cur_inc  = (r_cur == IW'(RING_DEPTH - 1)) ? '0 : r_cur + 1'b1;
        head_inc = (r_head == IW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
        tail_sum = {1'b0, r_head} + (IW + 1)'(r_count);
        tail     = (tail_sum >= (IW + 1)'(RING_DEPTH))
                 ? IW'(tail_sum - (IW + 1)'(RING_DEPTH)) : tail_sum[IW-1:0];
    end

    // Piece size: clip to max_piece, then to space left
    always_comb begin
        diff    = (oe > os) ? oe - os : '0;
        size_a  = (diff > AW'(r_max_piece)) ? r_max_piece : diff[PW-1:0];
        size_b  = (rrmq_pkg::SPACE_W'(size_a) > r_space) ? r_space[PW-1:0] : size_a;
        p_next  = r_p_s + AW'(r_p_size);
        drained = (p_next == r_p_en);
    end

    // Result of the decode step
    always_comb begin
        dec_status = rrmq_pkg::ST_OK;
        dec_akind  = rrmq_pkg::AKIND_NONE;
        case (r_kind)
            rrmq_pkg::KIND_RANGE: begin
                if (!full && bad) begin
                    dec_status = rrmq_pkg::ST_INVALID;
                end
            end
            rrmq_pkg::KIND_ANSWER: begin
                case (r_mode)
                    rrmq_pkg::MODE_HASH: begin
                        if (r_space < rrmq_pkg::SPACE_W'(r_hash_bytes)) begin
                            dec_status = rrmq_pkg::ST_NOSPACE;
                        end else begin
                            dec_akind = rrmq_pkg::AKIND_HASH;
                        end
                    end
                    rrmq_pkg::MODE_XFER: ;
                    default: dec_status = rrmq_pkg::ST_NODATA;
                endcase
            end
            default: ;
        endcase
    end

    // Memory port selection
    always_comb begin
        ram_raddr = i_cmd.walk_step ? r_cur : r_head;
        ram_we    = 1'b0;
        ram_waddr = r_cmp_idx;
        ram_wdata = {new_end, new_start};
        if (i_cmd.walk_step && hit) begin
            ram_we = 1'b1;
        end else if (i_cmd.append) begin
            ram_we    = 1'b1;
            ram_waddr = tail;
            ram_wdata = {r_e, b_ext};
        end else if (i_cmd.piece_apply && (r_p_size != '0)) begin
            ram_we    = 1'b1;
            ram_waddr = r_head;
            ram_wdata = {r_p_en, p_next};
        end
    end

    // Status to controller
    always_comb begin
        o_stat.need_walk  = (r_kind == rrmq_pkg::KIND_RANGE) && !full && !bad && !empty;
        o_stat.need_piece = (r_kind == rrmq_pkg::KIND_ANSWER)
                          && (r_mode == rrmq_pkg::MODE_XFER) && (r_count != '0);
        o_stat.hit        = hit;
        o_stat.walk_end   = (r_issued == r_count) && !hit;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // Configuration and ring control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= rrmq_pkg::IMAGE_SIZE_RST;
            r_max_piece  <= rrmq_pkg::MAX_PIECE_RST;
            r_hash_bytes <= rrmq_pkg::HASH_BYTES_RST;
            r_head       <= '0;
            r_count      <= '0;
            r_mode       <= rrmq_pkg::MODE_IDLE;
            r_cur        <= '0;
            r_issued     <= '0;
            r_cmp_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rrmq_pkg::CFG_IMAGE_SIZE: r_image_size <= i_cfg_wdata;
                    rrmq_pkg::CFG_MAX_PIECE:  r_max_piece  <= i_cfg_wdata[PW-1:0];
                    rrmq_pkg::CFG_HASH_BYTES: r_hash_bytes <= i_cfg_wdata[PW-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.decode) begin
                // Start a walk at the head
                r_cur       <= r_head;
                r_issued    <= '0;
                r_cmp_valid <= 1'b0;
                case (r_kind)
                    rrmq_pkg::KIND_HASH: r_mode <= rrmq_pkg::MODE_HASH;
                    rrmq_pkg::KIND_STOP: begin
                        r_mode  <= rrmq_pkg::MODE_IDLE;
                        r_count <= '0;
                        r_head  <= '0;
                    end
                    rrmq_pkg::KIND_ANSWER: begin
                        if (r_mode == rrmq_pkg::MODE_HASH) begin
                            if (r_space >= rrmq_pkg::SPACE_W'(r_hash_bytes)) begin
                                r_mode <= rrmq_pkg::MODE_IDLE;
                            end
                        end else if ((r_mode == rrmq_pkg::MODE_XFER) && (r_count == '0)) begin
                            r_mode <= rrmq_pkg::MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
            end

            // Issue the next entry read, compare the one read before
            if (i_cmd.walk_step) begin
                if (r_issued != r_count) begin
                    r_cur       <= cur_inc;
                    r_issued    <= r_issued + 1'b1;
                    r_cmp_valid <= 1'b1;
                end else begin
                    r_cmp_valid <= 1'b0;
                end
            end

            if (i_cmd.append) begin
                r_count <= r_count + 1'b1;
                r_mode  <= rrmq_pkg::MODE_XFER;
            end

            // Pop the head once drained
            if (i_cmd.piece_apply && (r_p_size != '0) && drained) begin
                r_head  <= head_inc;
                r_count <= r_count - 1'b1;
                if (r_count == CW'(1)) begin
                    r_mode <= rrmq_pkg::MODE_IDLE;
                end
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= rrmq_pkg::t_kind'(i_kind);
            r_b     <= i_range_begin;
            r_e     <= i_range_end;
            r_space <= i_space_left;
        end

        if (i_cmd.walk_step && (r_issued != r_count)) begin
            r_cmp_idx <= r_cur;
        end

        if (i_cmd.piece_calc) begin
            r_p_s    <= os;
            r_p_en   <= oe;
            r_p_size <= size_b;
        end

        if (i_cmd.decode) begin
            r_res_status <= dec_status;
            r_res_akind  <= dec_akind;
            r_res_off    <= '0;
            r_res_len    <= '0;
        end

        if (i_cmd.piece_apply) begin
            if (r_p_size == '0) begin
                r_res_status <= rrmq_pkg::ST_NOSPACE;
            end else begin
                r_res_akind <= rrmq_pkg::AKIND_CHUNK;
                r_res_off   <= r_p_s[rrmq_pkg::BEGIN_W-1:0];
                r_res_len   <= r_p_size;
            end
        end

        if (i_cmd.finish) begin
            r_out_status <= r_res_status;
            r_out_akind  <= r_res_akind;
            r_out_off    <= r_res_off;
            r_out_len    <= r_res_len;
            r_out_has    <= (r_mode != rrmq_pkg::MODE_IDLE);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_answer_kind  = r_out_akind;
    assign o_piece_offset = r_out_off;
    assign o_piece_length = r_out_len;
    assign o_has_answers  = r_out_has;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RING_DEPTH))
        else $error("pending count above ring depth");

    a_xfer_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == rrmq_pkg::MODE_XFER) |-> (r_count != '0))
        else $error("transferring with an empty ring");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> (r_issued <= r_count))
        else $error("walk ran past the pending entries");

    a_chunk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && (r_res_akind == rrmq_pkg::AKIND_CHUNK))
        |-> ((r_res_len != '0) && (r_res_len <= r_max_piece)))
        else $error("chunk piece length out of range");
endmodule
`default_nettype wire

/* design/range_request_merge_queue_unit.sv */
// Pending byte-range queue with merging. Requests come in on the slave stream
// (tuser = kind: range, hash, stop, answer) and each gives exactly one result on
// the master stream. A range request walks the pending entries from the head,
// one per cycle out of the ring memory, and widens the first range it touches
// or appends a new one; a full ring is not walked. An answer request with
// pending ranges reads the head entry. The next request is accepted in the
// cycle the result moves into the output register, and the output register
// holds a result until the master side takes it. Configuration (image_size,
// max_piece, hash_reply_bytes) is to be written by the user only while idle;
// the block itself does not enforce this.
`default_nettype none
module range_request_merge_queue_unit #(
    parameter int RING_DEPTH = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [23:0] range_begin, [48:24] range_end, [64:49] space_left, [71:65] zero
    input  wire logic [rrmq_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [1:0] kind
    input  wire logic [rrmq_pkg::KIND_W-1:0]         i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [1:0] status, [25:2] piece_offset, [38:26] piece_length, [39] has_answers
    output logic [rrmq_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    // [1:0] answer_kind
    output logic [rrmq_pkg::AKIND_W-1:0]             o_m_axis_tuser,
    input  wire logic                                i_cfg_we,
    input  wire logic [rrmq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rrmq_pkg::IMG_W-1:0]          i_cfg_wdata
);
    rrmq_pkg::t_cmd  cmd;
    rrmq_pkg::t_stat stat;

    logic [rrmq_pkg::STATUS_W-1:0] status;
    logic [rrmq_pkg::BEGIN_W-1:0]  piece_offset;
    logic [rrmq_pkg::PIECE_W-1:0]  piece_length;
    logic                          has_answers;

    rrmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rrmq_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_kind         (i_s_axis_tuser),
        .i_range_begin  (i_s_axis_tdata[23:0]),
        .i_range_end    (i_s_axis_tdata[48:24]),
        .i_space_left   (i_s_axis_tdata[64:49]),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_status       (status),
        .o_answer_kind  (o_m_axis_tuser),
        .o_piece_offset (piece_offset),
        .o_piece_length (piece_length),
        .o_has_answers  (has_answers)
    );

    // Pack the result
    assign o_m_axis_tdata = {has_answers, piece_length, piece_offset, status};
endmodule
`default_nettype wire
